// ===== rtl/falu_pkg.sv =====
// Shared types and constants for the Q-format fixed-point ALU.
// No dependencies; imported by every module of the block.
package falu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DIV_CELLS = 32;
    localparam int STAGES    = DIV_CELLS + 2;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_LT   = 4'd4,
        OP_GT   = 4'd5,
        OP_LE   = 4'd6,
        OP_GE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FROM = 4'd14,
        OP_TO   = 4'd15
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] res;
        logic               cmp;
        logic               ovf;
        logic        [31:0] rem;
        logic        [31:0] den;
        logic        [31:0] num;
        logic               neg;
        logic signed [63:0] prod;
    } t_cell;

endpackage

// ===== rtl/falu_prep.sv =====
// Entry cell: decodes the word, computes every operation but multiply and divide,
// forms the product and sets up the divider chain. Depends on falu_pkg.
module falu_prep import falu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic        [3:0]  i_operation,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output t_cell              o_q
);

    t_cell              r_q;
    t_cell              n_q;
    logic        [31:0] a_mag;
    logic        [31:0] b_mag;
    logic        [63:0] n64;
    logic signed [32:0] s_add;
    logic signed [32:0] s_sub;
    logic signed [32:0] s_inc;
    logic signed [32:0] s_dec;
    logic signed [31:0] to_bias;
    logic               lt;
    logic               eq;

    always_comb begin
        a_mag   = i_operand_a[31] ? (32'd0 - i_operand_a) : i_operand_a;
        b_mag   = i_operand_b[31] ? (32'd0 - i_operand_b) : i_operand_b;
        n64     = {32'd0, a_mag} << FRAC_BITS;
        s_add   = {i_operand_a[31], i_operand_a} + {i_operand_b[31], i_operand_b};
        s_sub   = {i_operand_a[31], i_operand_a} - {i_operand_b[31], i_operand_b};
        s_inc   = {i_operand_a[31], i_operand_a} + 33'sd1;
        s_dec   = {i_operand_a[31], i_operand_a} - 33'sd1;
        to_bias = i_operand_a[31] ? (i_operand_a + $signed({{(32 - FRAC_BITS){1'b0}},
                  {FRAC_BITS{1'b1}}})) : i_operand_a;
        lt      = i_operand_a < i_operand_b;
        eq      = i_operand_a == i_operand_b;

        n_q      = '0;
        n_q.op   = t_op'(i_operation);
        n_q.rem  = n64[63:32];
        n_q.num  = n64[31:0];
        n_q.den  = b_mag;
        n_q.neg  = i_operand_a[31] ^ i_operand_b[31];
        n_q.prod = i_operand_a * i_operand_b;

        case (t_op'(i_operation))
            OP_ADD: begin
                n_q.ovf = s_add[32] != s_add[31];
                n_q.res = n_q.ovf ? 32'sd0 : s_add[31:0];
            end
            OP_SUB: begin
                n_q.ovf = s_sub[32] != s_sub[31];
                n_q.res = n_q.ovf ? 32'sd0 : s_sub[31:0];
            end
            OP_INC: begin
                n_q.ovf = s_inc[32] != s_inc[31];
                n_q.res = n_q.ovf ? 32'sd0 : s_inc[31:0];
            end
            OP_DEC: begin
                n_q.ovf = s_dec[32] != s_dec[31];
                n_q.res = n_q.ovf ? 32'sd0 : s_dec[31:0];
            end
            OP_DIV: n_q.ovf = (b_mag == 32'd0) || (n64[63:32] >= b_mag);
            OP_LT:  n_q.cmp = lt;
            OP_GT:  n_q.cmp = !lt && !eq;
            OP_LE:  n_q.cmp = lt || eq;
            OP_GE:  n_q.cmp = !lt;
            OP_EQ:  n_q.cmp = eq;
            OP_NE:  n_q.cmp = !eq;
            OP_MIN: n_q.res = lt ? i_operand_a : i_operand_b;
            OP_MAX: n_q.res = (!lt && !eq) ? i_operand_a : i_operand_b;
            OP_FROM: begin
                n_q.ovf = i_operand_a[31:31 - FRAC_BITS] != {(FRAC_BITS + 1){i_operand_a[31]}};
                n_q.res = n_q.ovf ? 32'sd0 : (i_operand_a <<< FRAC_BITS);
            end
            OP_TO:  n_q.res = to_bias >>> FRAC_BITS;
            default: n_q.res = 32'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/falu_div_cell.sv =====
// One cell of the divider chain: develops one quotient bit and hands the word on.
// Depends on falu_pkg.
module falu_div_cell import falu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell       r_q;
    t_cell       n_q;
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
        r2    = {i_d.rem, i_d.num[31]};
        diff  = r2 - {1'b0, i_d.den};
        ge    = r2 >= {1'b0, i_d.den};
        n_q   = i_d;
        n_q.rem = ge ? diff[31:0] : r2[31:0];
        n_q.num = {i_d.num[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/falu_finish.sv =====
// Final cell: rounds and range-checks multiply and divide, holds the output word.
// Depends on falu_pkg.
module falu_finish import falu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cell              i_d,
    output logic signed [31:0] o_result_value,
    output logic               o_compare_true,
    output logic               o_overflow
);

    logic signed [31:0] r_res;
    logic               r_cmp;
    logic               r_ovf;
    logic signed [31:0] n_res;
    logic               n_cmp;
    logic               n_ovf;
    logic        [63:0] m;
    logic        [63:0] mq;
    logic        [63:0] mlim;
    logic        [63:0] mqr;
    logic               mneg;
    logic               mremnz;
    logic        [32:0] dlim;
    logic        [32:0] dqr;
    logic               dremnz;
    logic               drnd;

    always_comb begin
        mneg   = i_d.prod[63];
        m      = mneg ? (64'd0 - i_d.prod) : i_d.prod;
        mq     = m >> FRAC_BITS;
        mremnz = m[FRAC_BITS - 1:0] != '0;
        mlim   = mneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        mqr    = mq + {63'd0, m[FRAC_BITS - 1]};
        dlim   = i_d.neg ? 33'h1_0000_0000 >> 1 : 33'h0_7FFF_FFFF;
        dremnz = i_d.rem != 32'd0;
        drnd   = dremnz && ({i_d.rem, 1'b0} >= {1'b0, i_d.den});
        dqr    = {1'b0, i_d.num} + {32'd0, drnd};

        n_res = i_d.res;
        n_cmp = i_d.cmp;
        n_ovf = i_d.ovf;
        case (i_d.op)
            OP_MUL: begin
                n_ovf = (mq > mlim) || (mq == mlim && mremnz);
                n_res = n_ovf ? 32'sd0 : (mneg ? (32'sd0 - mqr[31:0]) : mqr[31:0]);
            end
            OP_DIV: begin
                n_ovf = i_d.ovf || ({1'b0, i_d.num} > dlim)
                        || ({1'b0, i_d.num} == dlim && dremnz);
                n_res = n_ovf ? 32'sd0 : (i_d.neg ? (32'sd0 - dqr[31:0]) : dqr[31:0]);
            end
            default: n_res = i_d.res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_cmp <= n_cmp;
            r_ovf <= n_ovf;
        end
    end

    assign o_result_value = r_res;
    assign o_compare_true = r_cmp;
    assign o_overflow     = r_ovf;

endmodule

// ===== rtl/fixed_point_alu_q24_8.sv =====
// Top level of the Q24.8 fixed-point ALU: entry cell, divider chain and output cell.
// Depends on falu_pkg, falu_prep, falu_div_cell and falu_finish.
// Usage: one word is accepted per cycle while o_in_ready is high and each gives exactly
// one result word, in order. Every operation passes the same 34 registers: one entry cell,
// a chain of 32 divider cells that each settle one quotient bit, and the output cell,
// which registers the result word; a stall holds every register of the chain.
// The whole chain advances together whenever the output word is empty or taken, so
// throughput is one word per cycle while the consumer keeps ready high.
module fixed_point_alu_q24_8 import falu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [3:0]  i_operation,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_value,
    output logic               o_compare_true,
    output logic               o_overflow
);

    logic [STAGES - 1:0] r_vld;
    logic [STAGES - 1:0] n_vld;
    logic                adv;
    t_cell               chain [DIV_CELLS + 1];

    assign adv        = !r_vld[STAGES - 1] || i_out_ready;
    assign o_in_ready = adv;
    assign n_vld      = {r_vld[STAGES - 2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= n_vld;
        end
    end

    falu_prep u_prep (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_q         (chain[0])
    );

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        falu_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (chain[g]),
            .o_q   (chain[g + 1])
        );
    end

    falu_finish u_finish (
        .i_clk          (i_clk),
        .i_en           (adv),
        .i_d            (chain[DIV_CELLS]),
        .o_result_value (o_result_value),
        .o_compare_true (o_compare_true),
        .o_overflow     (o_overflow)
    );

    assign o_out_valid = r_vld[STAGES - 1];

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_result_value == 32'sd0)
        else $error("overflow with non-zero result");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_compare_true |-> o_result_value == 32'sd0 && !o_overflow)
        else $error("comparison result carries value or overflow");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES - 2] && !adv |=> r_vld[STAGES - 2])
        else $error("chain lost a word while stalled");

endmodule

// ===== tb/tb_fixed_point_alu_q24_8.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Q24.8 fixed-point ALU: directed table, then random words.
// Depends on falu_pkg and fixed_point_alu_q24_8; results are checked against a local predictor.
module tb_fixed_point_alu_q24_8;
    import falu_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               ovf;
    } t_alu_res;

    typedef struct {
        t_op                op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               known;
        logic signed [31:0] value;
        logic               cmp;
        logic               ovf;
    } t_row;

    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic        [3:0]  i_operation = 4'd0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_result_value;
    logic               o_compare_true;
    logic               o_overflow;

    t_alu_res pending_q[$];
    int       mismatches = 0;
    t_row     rows[$];

    fixed_point_alu_q24_8 uut (.*);

    always #6 i_clk = ~i_clk;

    function automatic t_alu_res fit(logic sgn, logic [63:0] q, logic [63:0] r,
                                     logic [63:0] d);
        t_alu_res x;
        logic [63:0] lim;
        x = '{0, 1'b0, 1'b0};
        lim = sgn ? 64'd2147483648 : 64'd2147483647;
        if (q > lim || (q == lim && r != 0)) begin
            x.ovf = 1'b1;
        end else begin
            if (r != 0 && r * 2 >= d) q++;
            x.value = sgn ? -q[31:0] : q[31:0];
        end
        return x;
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_alu_res alu_predict(t_op op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_res x;
        logic signed [63:0] wa, wb, p;
        logic [63:0] n, d;
        wa = a;
        wb = b;
        x = '{0, 1'b0, 1'b0};
        case (op)
            OP_ADD: x = fit(wa + wb < 0, mag(wa + wb), 64'd0, 64'd1);
            OP_SUB: x = fit(wa - wb < 0, mag(wa - wb), 64'd0, 64'd1);
            OP_MUL: begin
                p = wa * wb;
                n = mag(p);
                x = fit(p < 0, n >> FRAC_BITS, n & ((64'd1 << FRAC_BITS) - 1),
                        64'd1 << FRAC_BITS);
            end
            OP_DIV: begin
                if (b == 0) begin
                    x.ovf = 1'b1;
                end else begin
                    n = mag(wa) << FRAC_BITS;
                    d = mag(wb);
                    x = fit((a < 0) != (b < 0), n / d, n % d, d);
                end
            end
            OP_LT:  x.cmp = a < b;
            OP_GT:  x.cmp = a > b;
            OP_LE:  x.cmp = a <= b;
            OP_GE:  x.cmp = a >= b;
            OP_EQ:  x.cmp = a == b;
            OP_NE:  x.cmp = a != b;
            OP_MIN: x.value = a < b ? a : b;
            OP_MAX: x.value = a > b ? a : b;
            OP_INC: x = fit(wa + 1 < 0, mag(wa + 1), 64'd0, 64'd1);
            OP_DEC: x = fit(wa - 1 < 0, mag(wa - 1), 64'd0, 64'd1);
            OP_FROM: begin
                if (wa > (64'sd2147483647 >>> FRAC_BITS) ||
                    wa < -(64'sd2147483647 >>> FRAC_BITS) - 1)
                    x.ovf = 1'b1;
                else
                    x.value = a <<< FRAC_BITS;
            end
            default: x.value = 32'(wa / (64'sd1 << FRAC_BITS));
        endcase
        return x;
    endfunction

    task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic add_row(t_op op, logic signed [31:0] a, logic signed [31:0] b,
                           logic known = 1'b0, logic signed [31:0] v = 0,
                           logic c = 1'b0, logic o = 1'b0);
        rows.push_back('{op, a, b, known, v, c, o});
    endtask

    task automatic send_word(t_op op, logic signed [31:0] a, logic signed [31:0] b,
                             int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pending_q.push_back(alu_predict(op, a, b));
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) == 0 ? SMAX : SMIN;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            3: return ($urandom_range(0, 1) ? 32'sd8388607 : -32'sd8388608)
                      + $signed($urandom_range(0, 4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_alu_res w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected word", o_result_value, 0);
            end else begin
                w = pending_q.pop_front();
                if (o_result_value !== w.value) report("value", o_result_value, w.value);
                if (o_compare_true !== w.cmp)
                    report("compare", 32'(o_compare_true), 32'(w.cmp));
                if (o_overflow !== w.ovf)
                    report("overflow", 32'(o_overflow), 32'(w.ovf));
            end
        end
    end

    initial begin
        int gap;
        @(negedge i_clk);
        while (1) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        t_op op;
        t_alu_res w;
        add_row(OP_ADD, SMAX, 1, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_ADD, SMIN, -1, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_SUB, SMIN, 1, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_SUB, 0, SMIN, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_MUL, SMIN, SMIN, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_MUL, 384, -128);
        add_row(OP_MUL, SMAX, 256, 1'b1, SMAX, 1'b0, 1'b0);
        add_row(OP_DIV, 256, 0, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_DIV, SMIN, -256, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_DIV, 1, 512);
        add_row(OP_DIV, -1, 3);
        add_row(OP_LT, SMIN, SMAX, 1'b1, 0, 1'b1, 1'b0);
        add_row(OP_GT, SMIN, SMAX, 1'b1, 0, 1'b0, 1'b0);
        add_row(OP_LE, 5, 5, 1'b1, 0, 1'b1, 1'b0);
        add_row(OP_GE, -5, 5, 1'b1, 0, 1'b0, 1'b0);
        add_row(OP_EQ, SMAX, SMAX, 1'b1, 0, 1'b1, 1'b0);
        add_row(OP_NE, SMAX, SMAX, 1'b1, 0, 1'b0, 1'b0);
        add_row(OP_MIN, SMIN, SMAX, 1'b1, SMIN, 1'b0, 1'b0);
        add_row(OP_MAX, SMIN, SMAX, 1'b1, SMAX, 1'b0, 1'b0);
        add_row(OP_INC, SMAX, 0, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_DEC, SMIN, 0, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_FROM, 32'sd8388608, 0, 1'b1, 0, 1'b0, 1'b1);
        add_row(OP_FROM, -32'sd8388608, 0, 1'b1, SMIN, 1'b0, 1'b0);
        add_row(OP_TO, -32'sd257, 0, 1'b1, -1, 1'b0, 1'b0);
        add_row(OP_TO, SMIN, SMAX);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].known) begin
                w = alu_predict(rows[k].op, rows[k].a, rows[k].b);
                if (w.value !== rows[k].value || w.cmp !== rows[k].cmp ||
                    w.ovf !== rows[k].ovf)
                    report("table row", k, 0);
            end
            send_word(rows[k].op, rows[k].a, rows[k].b, $urandom_range(0, 19));
        end
        i_in_valid <= 1'b0;

        wait (pending_q.size() == 0);
        @(negedge i_clk);

        for (int n = 0; n < 900; n++) begin
            op = t_op'($urandom_range(0, 15));
            if (n == 450) begin
                i_in_valid <= 1'b0;
                wait (pending_q.size() == 0);
                @(negedge i_clk);
            end
            if ((n % 100) < 8)
                send_word(op, pick_operand(), pick_operand(), 0);
            else
                send_word(op, pick_operand(), pick_operand(), $urandom_range(0, 19));
        end
        i_in_valid <= 1'b0;

        wait (pending_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("tb_fixed_point_alu_q24_8 OK");
        else
            $display("tb_fixed_point_alu_q24_8 NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_fixed_point_alu_q24_8 NOT OK");
        $finish;
    end

endmodule
